// ===== sv/bqp_pkg.sv =====
// ----------------------------------------------------------------------------
// bqp_pkg
// shared types and constants of the box-constrained qp coordinate ascent unit
// ----------------------------------------------------------------------------
`default_nettype none

package bqp_pkg;

    localparam int MAX_DIM_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int WGT_W   = 31;
    localparam int ITER_W  = 16;
    localparam int SIZE_W  = 7;
    localparam int CFG_W   = 31;
    localparam int CIDX_W  = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BOX_LIMIT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_ITER  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TOLERANCE = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SIZE      = 2'd3;

    localparam logic [CFG_W-1:0]  BOX_LIMIT_RST = 31'd65536;
    localparam logic [ITER_W-1:0] MAX_ITER_RST  = 16'd10000;
    localparam logic [CFG_W-1:0]  TOLERANCE_RST = 31'd1;
    localparam logic [SIZE_W-1:0] SIZE_RST      = 7'd64;

    // one loaded matrix request after classification
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    in_range;
        logic                    last;
    } entry_t;

    // solver settings handed to the back end
    typedef struct packed {
        logic [CFG_W-1:0]  box_limit;
        logic [ITER_W-1:0] max_iterations;
        logic [CFG_W-1:0]  tolerance;
        logic [SIZE_W-1:0] size_in_use;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/bqp_ram.sv =====
// ----------------------------------------------------------------------------
// bqp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bqp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/bqp_front.sv =====
// ----------------------------------------------------------------------------
// bqp_front
// accepts matrix requests, checks their position and queues them
// ----------------------------------------------------------------------------
`default_nettype none

module bqp_front #(
    parameter int MAX_DIM = bqp_pkg::MAX_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bqp_pkg::IDX_W-1:0]     row_index,
    input  wire logic [bqp_pkg::IDX_W-1:0]     col_index,
    input  wire logic signed [bqp_pkg::VAL_W-1:0] entry_value,
    input  wire logic                          last_entry,
    output logic                               q_valid,
    output bqp_pkg::entry_t                    q_entry,
    input  wire logic                          q_pop
);

    import bqp_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    entry_t     cls;
    logic       push;

    always_comb
    begin
        cls.row      = row_index;
        cls.col      = col_index;
        cls.value    = entry_value;
        cls.in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
        cls.last     = last_entry;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bqp_back.sv =====
// ----------------------------------------------------------------------------
// bqp_back
// stores matrix entries and runs the coordinate ascent solve and weight emit
// ----------------------------------------------------------------------------
`default_nettype none

module bqp_back #(
    parameter int MAX_DIM = bqp_pkg::MAX_DIM_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  bqp_pkg::entry_t                  q_entry,
    output logic                             q_pop,
    input  bqp_pkg::cfg_t                    cfg,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [bqp_pkg::IDX_W-1:0]        weight_index,
    output logic [bqp_pkg::WGT_W-1:0]        weight_value,
    output logic                             converged,
    output logic [bqp_pkg::ITER_W-1:0]       sweeps_used,
    output logic                             last_weight
);

    import bqp_pkg::*;

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int NUM_W = 49;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_RD, S_LD, S_DIV, S_STEP, S_URD, S_UMUL, S_UWR,
        S_NEXT, S_ERD, S_ELD, S_EWAIT
    } state_t;

    state_t                    state_reg;
    logic [IW-1:0]             i_reg;
    logic [IW-1:0]             j_reg;
    logic [IW-1:0]             n_m1_reg;
    logic [ITER_W-1:0]         it_reg;
    logic [WGT_W-1:0]          maxd_reg;
    logic [WGT_W-1:0]          d_reg;
    logic [WGT_W-1:0]          oldv_reg;
    logic                      neg_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [32:0]               rem_reg;
    logic [NUM_W-1:0]          quo_reg;
    logic [5:0]                cnt_reg;
    logic signed [31:0]        delta_reg;
    logic signed [63:0]        prod_reg;
    logic signed [31:0]        ph_reg;
    logic                      conv_reg;

    // ram ports
    logic                      m_we;
    logic [AW-1:0]             m_waddr;
    logic [AW-1:0]             m_raddr;
    logic [VAL_W-1:0]          m_rdata;
    logic                      w_we;
    logic [IW-1:0]             w_waddr;
    logic [WGT_W-1:0]          w_wdata;
    logic [IW-1:0]             w_raddr;
    logic [WGT_W-1:0]          w_rdata;
    logic                      p_we;
    logic [IW-1:0]             p_waddr;
    logic [VAL_W-1:0]          p_wdata;
    logic [IW-1:0]             p_raddr;
    logic [VAL_W-1:0]          p_rdata;

    // datapath helpers
    logic signed [49:0]        sq;
    logic signed [50:0]        sum;
    logic [WGT_W-1:0]          nv;
    logic signed [31:0]        delta;
    logic [31:0]               ad;
    logic [32:0]               trial;
    logic                      qbit;
    logic signed [33:0]        t;
    logic [32:0]               mag;
    logic signed [47:0]        term;
    logic signed [48:0]        psum;
    logic signed [31:0]        psat;
    logic [ITER_W-1:0]         it_inc;
    logic [IW-1:0]             n_m1;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
    endfunction

    // square matrix store, column reads for the update, diagonal reads for the step
    bqp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM * MAX_DIM)) u_mat (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(q_entry.value),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    bqp_ram #(.WIDTH(WGT_W), .DEPTH(MAX_DIM)) u_wgt (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    bqp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_prd (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    always_comb
    begin
        if (cfg.size_in_use == '0)
        begin
            n_m1 = '0;
        end
        else if (int'(cfg.size_in_use) > MAX_DIM)
        begin
            n_m1 = IW'(MAX_DIM - 1);
        end
        else
        begin
            n_m1 = IW'(cfg.size_in_use - 7'd1);
        end

        // step: clip old weight plus signed quotient
        sq    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        sum   = $signed({20'd0, oldv_reg}) + 51'(sq);
        if (sum < 0)
        begin
            nv = '0;
        end
        else if (sum > $signed({20'd0, cfg.box_limit}))
        begin
            nv = cfg.box_limit;
        end
        else
        begin
            nv = sum[WGT_W-1:0];
        end
        delta = $signed({1'b0, nv}) - $signed({1'b0, oldv_reg});
        ad    = (delta < 0) ? 32'(-delta) : 32'(delta);

        // one restoring division step
        trial = {rem_reg[31:0], num_reg[NUM_W-1]};
        qbit  = (trial >= {2'b00, d_reg});

        t   = 34'sd65536 - 34'($signed(p_rdata));
        mag = (t < 0) ? 33'(-t) : 33'(t);

        // floor shift of the column product, then saturate
        term = prod_reg[63:16];
        psum = 49'(ph_reg) + 49'(term);
        if (psum > 49'sd2147483647)
        begin
            psat = 32'sh7fffffff;
        end
        else if (psum < -49'sd2147483648)
        begin
            psat = 32'sh80000000;
        end
        else
        begin
            psat = psum[31:0];
        end

        it_inc = it_reg + 16'd1;

        q_pop   = (state_reg == S_IDLE) && q_valid;
        m_we    = q_pop && q_entry.in_range;
        m_waddr = addr_of(IW'(q_entry.row), IW'(q_entry.col));
        m_raddr = (state_reg == S_URD) ? addr_of(j_reg, i_reg) : addr_of(i_reg, i_reg);

        w_we    = (state_reg == S_CLR) || ((state_reg == S_STEP) && (delta != 0));
        w_waddr = (state_reg == S_CLR) ? j_reg : i_reg;
        w_wdata = (state_reg == S_CLR) ? '0 : nv;
        w_raddr = (state_reg == S_ERD) ? j_reg : i_reg;

        p_we    = (state_reg == S_CLR) || (state_reg == S_UWR);
        p_waddr = j_reg;
        p_wdata = (state_reg == S_CLR) ? '0 : psat;
        p_raddr = (state_reg == S_URD) ? j_reg : i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            n_m1_reg     <= '0;
            it_reg       <= '0;
            maxd_reg     <= '0;
            d_reg        <= '0;
            oldv_reg     <= '0;
            neg_reg      <= 1'b0;
            num_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            cnt_reg      <= '0;
            delta_reg    <= '0;
            prod_reg     <= '0;
            ph_reg       <= '0;
            conv_reg     <= 1'b0;
            out_valid    <= 1'b0;
            weight_index <= '0;
            weight_value <= '0;
            converged    <= 1'b0;
            sweeps_used  <= '0;
            last_weight  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_entry.last)
                    begin
                        n_m1_reg  <= n_m1;
                        j_reg     <= '0;
                        it_reg    <= '0;
                        conv_reg  <= 1'b0;
                        state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    if (j_reg == n_m1_reg)
                    begin
                        j_reg    <= '0;
                        i_reg    <= '0;
                        maxd_reg <= '0;
                        state_reg <= (cfg.max_iterations == '0) ? S_ERD : S_RD;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_LD;
                end
                S_LD:
                begin
                    d_reg     <= ($signed(m_rdata) < 32'sd1) ? 31'd1 : m_rdata[WGT_W-1:0];
                    oldv_reg  <= w_rdata;
                    neg_reg   <= (t < 0);
                    num_reg   <= {mag[32:0], 16'd0};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= 6'(NUM_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= qbit ? (trial - {2'b00, d_reg}) : trial;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[NUM_W-2:0], qbit};
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_STEP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_STEP:
                begin
                    if (delta == 0)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        delta_reg <= delta;
                        if (ad[WGT_W-1:0] > maxd_reg)
                        begin
                            maxd_reg <= ad[WGT_W-1:0];
                        end
                        j_reg     <= '0;
                        state_reg <= S_URD;
                    end
                end
                S_URD:
                begin
                    state_reg <= S_UMUL;
                end
                S_UMUL:
                begin
                    prod_reg  <= delta_reg * $signed(m_rdata);
                    ph_reg    <= $signed(p_rdata);
                    state_reg <= S_UWR;
                end
                S_UWR:
                begin
                    if (j_reg == n_m1_reg)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_URD;
                    end
                end
                S_NEXT:
                begin
                    if (i_reg == n_m1_reg)
                    begin
                        it_reg <= it_inc;
                        i_reg  <= '0;
                        j_reg  <= '0;
                        if (maxd_reg < cfg.tolerance)
                        begin
                            conv_reg  <= 1'b1;
                            state_reg <= S_ERD;
                        end
                        else if (it_inc == cfg.max_iterations)
                        begin
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            maxd_reg  <= '0;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_ELD;
                end
                S_ELD:
                begin
                    out_valid    <= 1'b1;
                    weight_index <= IDX_W'(j_reg);
                    weight_value <= w_rdata;
                    converged    <= conv_reg;
                    sweeps_used  <= it_reg;
                    last_weight  <= (j_reg == n_m1_reg);
                    state_reg    <= S_EWAIT;
                end
                S_EWAIT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (last_weight)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_wgt_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (weight_value <= cfg.box_limit))
        else $error("weight outside box");

    a_pop_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && !out_valid))
        else $error("queue pop while busy or empty");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_weight && !out_stall) |=> (!out_valid && state_reg == S_IDLE))
        else $error("emit did not end after last weight");

    a_no_sweep_past_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (it_reg < cfg.max_iterations))
        else $error("sweep beyond iteration limit");

endmodule

`default_nettype wire

// ===== sv/box_qp_coordinate_ascent_unit.sv =====
// ----------------------------------------------------------------------------
// box_qp_coordinate_ascent_unit
// box-constrained dual qp solver by cyclic coordinate ascent, signed q16.16
// ----------------------------------------------------------------------------
// Matrix requests (row, column, value) are taken one per cycle, while there is
// room, into a two-deep queue and written to the matrix store by the back end
// at one per cycle while it is idle. The request marked last_entry is stored
// and then starts a solve: weights and the running product are cleared, then
// each sweep visits every coordinate. Each coordinate runs the bit-serial
// divider (49 quotient bits, one a cycle) and, when its weight changes, the
// column update (one shared multiplier, one matrix read port). Sweeps stop
// when the largest change falls below the tolerance or after max_iterations
// sweeps. The n weights then leave one at a time, each held until taken.
// Requests that arrive during a solve wait in the queue, and the input stalls
// once it is full. Configuration must be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module box_qp_coordinate_ascent_unit #(
    parameter int MAX_DIM = bqp_pkg::MAX_DIM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [bqp_pkg::CIDX_W-1:0]       cfg_index,
    input  wire logic [bqp_pkg::CFG_W-1:0]        cfg_data,
    // matrix requests
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [bqp_pkg::IDX_W-1:0]        row_index,
    input  wire logic [bqp_pkg::IDX_W-1:0]        col_index,
    input  wire logic signed [bqp_pkg::VAL_W-1:0] entry_value,
    input  wire logic                             last_entry,
    // weight results
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [bqp_pkg::IDX_W-1:0]             weight_index,
    output logic [bqp_pkg::WGT_W-1:0]             weight_value,
    output logic                                  converged,
    output logic [bqp_pkg::ITER_W-1:0]            sweeps_used,
    output logic                                  last_weight
);

    import bqp_pkg::*;

    cfg_t   cfg_reg;
    logic   q_valid;
    entry_t q_entry;
    logic   q_pop;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_limit      <= BOX_LIMIT_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
            cfg_reg.tolerance      <= TOLERANCE_RST;
            cfg_reg.size_in_use    <= SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_LIMIT: cfg_reg.box_limit      <= cfg_data;
                REG_MAX_ITER:  cfg_reg.max_iterations <= cfg_data[ITER_W-1:0];
                REG_TOLERANCE: cfg_reg.tolerance      <= cfg_data;
                REG_SIZE:      cfg_reg.size_in_use    <= cfg_data[SIZE_W-1:0];
                default:       cfg_reg.size_in_use    <= cfg_reg.size_in_use;
            endcase
        end
    end

    // front end: accept, range check and queue
    bqp_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .row_index(row_index), .col_index(col_index),
        .entry_value(entry_value), .last_entry(last_entry),
        .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
    );

    // back end: store, solve, emit
    bqp_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
        .cfg(cfg_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .weight_index(weight_index), .weight_value(weight_value),
        .converged(converged), .sweeps_used(sweeps_used),
        .last_weight(last_weight)
    );

endmodule

`default_nettype wire

// ===== bench/box_qp_coordinate_ascent_unit_tb.sv =====
// ----------------------------------------------------------------------------
// box_qp_coordinate_ascent_unit_tb
// self-checking bench for the box-constrained qp coordinate ascent unit
// ----------------------------------------------------------------------------
// A directed table covers register extremes, degenerate diagonals, zero
// iterations, zero tolerance and a zero size. Random phases then load
// small matrices and solve them under random settings. Every weight is
// checked against a bit-exact solver kept here or typed in a directed row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_qp_coordinate_ascent_unit_tb;
    import bqp_pkg::*;

    localparam int DIM        = MAX_DIM_DEF;
    localparam int STALL_PCT  = 14;
    localparam int IDLE_LIMIT = 100000;
    localparam int N_RANDOM   = 330;

    // one weight as the unit should present it
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [WGT_W-1:0]  wgt;
        logic              conv;
        logic [ITER_W-1:0] sweeps;
        logic              last;
    } weight_t;

    // one directed row: optional settings change, then one request
    typedef struct {
        bit                set_cfg;
        logic [CFG_W-1:0]  box;
        logic [ITER_W-1:0] iters;
        logic [CFG_W-1:0]  tol;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  val;
        bit                last;
        bit                typed;
        logic [WGT_W-1:0]  w;
        bit                cv;
        logic [ITER_W-1:0] sw;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CIDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last_entry;
    logic                    out_valid;
    logic                    out_stall;
    logic [IDX_W-1:0]        weight_index;
    logic [WGT_W-1:0]        weight_value;
    logic                    converged;
    logic [ITER_W-1:0]       sweeps_used;
    logic                    last_weight;

    // solver copy: settings, matrix store, which entries hold data
    longint            mstore [DIM*DIM];
    bit                written [DIM*DIM];
    logic [CFG_W-1:0]  box_q;
    logic [ITER_W-1:0] iters_q;
    logic [CFG_W-1:0]  tol_q;
    logic [SIZE_W-1:0] size_q;

    weight_t  pending_weights [$];
    dir_row_t dir_table [$];

    int  fail_count;
    int  requests_taken;
    int  solves_run;
    int  weights_seen;
    int  idle_cycles;
    bit  quiet;

    box_qp_coordinate_ascent_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_index    (row_index),
        .col_index    (col_index),
        .entry_value  (entry_value),
        .last_entry   (last_entry),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .converged    (converged),
        .sweeps_used  (sweeps_used),
        .last_weight  (last_weight)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // effective dimension: zero acts as one, oversize clamps to the store
    function automatic int dim_in_use();
        int n;
        n = size_q;
        if (n < 1) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    // cyclic coordinate ascent, queues the n weights it settles on
    task automatic solve_weights(int n);
        longint  w [DIM];
        longint  p [DIM];
        longint  d, nv, delta, ad, maxd, term, acc;
        int      it, sweeps;
        bit      conv;
        weight_t r;
        for (int i = 0; i < DIM; i++)
        begin
            w[i] = 0;
            p[i] = 0;
        end
        conv   = 1'b0;
        sweeps = 0;
        for (it = 0; it < int'(iters_q); it++)
        begin
            maxd = 0;
            for (int i = 0; i < n; i++)
            begin
                d = mstore[i*DIM + i];
                if (d < 1) d = 1;
                nv = w[i] + ((64'sd65536 - p[i]) * 64'sd65536) / d;
                if (nv < 0) nv = 0;
                if (nv > longint'(box_q)) nv = longint'(box_q);
                delta = nv - w[i];
                if (delta != 0)
                begin
                    w[i] = nv;
                    for (int j = 0; j < n; j++)
                    begin
                        term = (delta * mstore[j*DIM + i]) >>> 16;
                        acc  = p[j] + term;
                        // running product saturates at 32 bits
                        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                        p[j] = acc;
                    end
                    ad = (delta < 0) ? -delta : delta;
                    if (ad > maxd) maxd = ad;
                end
            end
            sweeps = it + 1;
            if (maxd < longint'(tol_q))
            begin
                conv = 1'b1;
                break;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.idx    = IDX_W'(i);
            r.wgt    = WGT_W'(w[i]);
            r.conv   = conv;
            r.sweeps = ITER_W'(sweeps);
            r.last   = (i == n - 1);
            pending_weights.push_back(r);
        end
    endtask

    // typed weights of a directed row: identical for every coordinate
    task automatic expect_uniform(logic [WGT_W-1:0] w, bit cv, logic [ITER_W-1:0] sw);
        weight_t r;
        int      n;
        n = dim_in_use();
        for (int i = 0; i < n; i++)
        begin
            r.idx    = IDX_W'(i);
            r.wgt    = w;
            r.conv   = cv;
            r.sweeps = sw;
            r.last   = (i == n - 1);
            pending_weights.push_back(r);
        end
    endtask

    // present one request, hold it while stalled, predict on acceptance
    task automatic send_request(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                logic [VAL_W-1:0] v, bit last, bit typed,
                                logic [WGT_W-1:0] w, bit cv, logic [ITER_W-1:0] sw);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        row_index   <= r;
        col_index   <= c;
        entry_value <= v;
        last_entry  <= last;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        requests_taken++;
        mstore[r*DIM + c]  = longint'(signed'(v));
        written[r*DIM + c] = 1'b1;
        if (last)
        begin
            solves_run++;
            if (typed)
                expect_uniform(w, cv, sw);
            else
                solve_weights(dim_in_use());
        end
    endtask

    // sender stops until every queued weight has come back
    task automatic wait_weights();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(negedge clk);
    endtask

    // settings change only while idle; trailing stores get time to land
    task automatic write_settings(logic [CFG_W-1:0] box, logic [ITER_W-1:0] iters,
                                  logic [CFG_W-1:0] tol, logic [SIZE_W-1:0] size);
        wait_weights();
        repeat (40) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BOX_LIMIT;
        cfg_data  <= box;
        @(negedge clk);
        cfg_index <= REG_MAX_ITER;
        cfg_data  <= CFG_W'(iters);
        @(negedge clk);
        cfg_index <= REG_TOLERANCE;
        cfg_data  <= tol;
        @(negedge clk);
        cfg_index <= REG_SIZE;
        cfg_data  <= CFG_W'(size);
        @(negedge clk);
        cfg_we    <= 1'b0;
        box_q   = box;
        iters_q = iters;
        tol_q   = tol;
        size_q  = size;
    endtask

    function automatic logic [VAL_W-1:0] pick_value(bit diag);
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return '0;
            default:
            begin
                if (diag)
                    return 32'(65536 * $urandom_range(1, 4) + $urandom_range(0, 65535));
                return 32'($urandom_range(0, 131071)) - 32'd65536;
            end
        endcase
    endfunction

    // one matrix load ending in a solve, with stray writes mixed in
    task automatic load_and_solve();
        int n, rr, cc;
        bit full;
        n    = dim_in_use();
        full = 1'b1;
        for (int i = 0; i < n*n; i++)
            if (!written[(i / n)*DIM + (i % n)]) full = 1'b0;
        // a block already loaded may be re-solved after a single touch
        if (full && $urandom_range(3) == 0)
        begin
            rr = $urandom_range(n - 1);
            cc = $urandom_range(n - 1);
            send_request(IDX_W'(rr), IDX_W'(cc), pick_value(rr == cc), 1'b1, 1'b0,
                         '0, 1'b0, '0);
            return;
        end
        for (int i = 0; i < n*n; i++)
        begin
            if ($urandom_range(7) == 0)
                send_request(IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, 1'b0,
                             '0, 1'b0, '0);
            rr = i / n;
            cc = i % n;
            send_request(IDX_W'(rr), IDX_W'(cc), pick_value(rr == cc), i == n*n - 1, 1'b0,
                         '0, 1'b0, '0);
        end
    endtask

    function automatic void add_row(bit sc, logic [CFG_W-1:0] box, logic [ITER_W-1:0] it,
                                    logic [CFG_W-1:0] tol, logic [SIZE_W-1:0] sz,
                                    logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                    logic [VAL_W-1:0] v, bit last, bit typed,
                                    logic [WGT_W-1:0] w, bit cv, logic [ITER_W-1:0] sw);
        dir_row_t d;
        d = '{sc, box, it, tol, sz, r, c, v, last, typed, w, cv, sw};
        dir_table.push_back(d);
    endfunction

    // weight checker
    always @(posedge clk)
    begin
        weight_t e;
        if (out_valid && !out_stall)
        begin
            weights_seen++;
            if (pending_weights.size() == 0)
            begin
                $error("weight with none expected: index %0d value %0d",
                       weight_index, weight_value);
                fail_count++;
            end
            else
            begin
                e = pending_weights.pop_front();
                if (weight_index !== e.idx)
                begin
                    $error("weight_index expected %0d got %0d", e.idx, weight_index);
                    fail_count++;
                end
                if (weight_value !== e.wgt)
                begin
                    $error("weight_value expected %0d got %0d", e.wgt, weight_value);
                    fail_count++;
                end
                if (converged !== e.conv)
                begin
                    $error("converged expected %0d got %0d", e.conv, converged);
                    fail_count++;
                end
                if (sweeps_used !== e.sweeps)
                begin
                    $error("sweeps_used expected %0d got %0d", e.sweeps, sweeps_used);
                    fail_count++;
                end
                if (last_weight !== e.last)
                begin
                    $error("last_weight expected %0d got %0d", e.last, last_weight);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < STALL_PCT);

    // watchdog on cycles with no request and no weight moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d weights still due", pending_weights.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase;
        fail_count     = 0;
        requests_taken = 0;
        solves_run     = 0;
        weights_seen   = 0;
        idle_cycles    = 0;
        quiet          = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_BOX_LIMIT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        row_index   = '0;
        col_index   = '0;
        entry_value = '0;
        last_entry  = 1'b0;
        out_stall   = 1'b0;
        box_q   = BOX_LIMIT_RST;
        iters_q = MAX_ITER_RST;
        tol_q   = TOLERANCE_RST;
        size_q  = SIZE_RST;
        for (int i = 0; i < DIM*DIM; i++)
        begin
            mstore[i]  = 0;
            written[i] = 1'b0;
        end

        // single coordinate: unit, zero, most negative and most positive diagonal
        add_row(1, 31'd65536, 16'd10000, 31'd1, 7'd1, 0, 0, 32'd65536, 1, 1, 31'd65536, 1, 2);
        add_row(0, 0, 0, 0, 0, 0, 0, 32'd0, 1, 1, 31'd65536, 1, 2);
        add_row(0, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 1, 31'd65536, 1, 2);
        add_row(0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 1, 1, 31'd2, 1, 2);
        // zero iterations, zero size acts as one
        add_row(1, 31'd0, 16'd0, 31'd0, 7'd0, 0, 0, 32'd12345, 1, 1, 31'd0, 0, 0);
        // zero box limit: nothing moves, converges on the first sweep
        add_row(1, 31'd0, 16'd65535, 31'h7fff_ffff, 7'd3, 63, 63, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 63, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 9; i++)
            add_row(0, 0, 0, 0, 0, IDX_W'(i / 3), IDX_W'(i % 3), 32'(i * 40000) - 32'd100000,
                    i == 8, i == 8, 31'd0, 1, 1);
        // widest box, one sweep, zero tolerance
        add_row(1, 31'h7fff_ffff, 16'd1, 31'd0, 7'd2, 0, 0, 32'd65536, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 1, 32'hffff_ffff, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 1, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 1, 1, 32'h8000_0000, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 1, 1, 32'd131072, 1, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_table[k])
        begin
            if (dir_table[k].set_cfg)
                write_settings(dir_table[k].box, dir_table[k].iters,
                               dir_table[k].tol, dir_table[k].size);
            send_request(dir_table[k].row, dir_table[k].col, dir_table[k].val,
                         dir_table[k].last, dir_table[k].typed,
                         dir_table[k].w, dir_table[k].cv, dir_table[k].sw);
        end

        // random phases of small solves under random settings
        phase = 0;
        while (requests_taken < N_RANDOM)
        begin
            logic [CFG_W-1:0]  box;
            logic [CFG_W-1:0]  tol;
            logic [SIZE_W-1:0] sz;
            case ($urandom_range(3))
                0: box = 31'($urandom);
                1: box = 31'(65536 * $urandom_range(1, 8));
                2: box = 31'($urandom_range(0, 4096));
                default: box = 31'h7fff_ffff;
            endcase
            case ($urandom_range(3))
                0: tol = '0;
                1: tol = 31'($urandom_range(1, 64));
                2: tol = 31'($urandom_range(0, 1 << 20));
                default: tol = 31'($urandom);
            endcase
            sz = ($urandom_range(9) == 0) ? 7'($urandom_range(5, 8)) : 7'($urandom_range(0, 4));
            quiet = (phase >= 3 && phase < 6);
            write_settings(box, 16'($urandom_range(1, 8)), tol, sz);
            repeat ($urandom_range(2, 4))
            begin
                load_and_solve();
                if (phase == 0 || $urandom_range(3) == 0)
                    wait_weights();
            end
            phase++;
        end
        quiet = 1'b0;

        wait_weights();
        repeat (200) @(negedge clk);
        $display("%0d requests loaded, %0d solves, %0d weights checked, %0d mismatches",
                 requests_taken, solves_run, weights_seen, fail_count);
        $display("settings ranged over box, sweep and tolerance extremes, sizes 1 to 8");
        if (fail_count == 0 && pending_weights.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== box_qp_coordinate_ascent_unit.f =====
sv/bqp_pkg.sv
sv/bqp_ram.sv
sv/bqp_front.sv
sv/bqp_back.sv
sv/box_qp_coordinate_ascent_unit.sv
bench/box_qp_coordinate_ascent_unit_tb.sv
